@@ hdl/hec_pkg.sv @@
// Package with the beat types, configuration types and code layout functions of the Hamming block.
package hec_pkg;

	localparam int MAX_CODE_BITS = 63;
	localparam int DATA_BITS     = 57;
	localparam int CODE_BITS     = 63;
	localparam int LEN_BITS      = 6;
	localparam int PAR_BITS      = 3;
	localparam int MAX_PARITY    = 6;
	localparam logic [LEN_BITS-1:0] RESET_LENGTH = 6'd4;

	typedef struct packed {
		logic [DATA_BITS-1:0] data_word;
		logic [CODE_BITS-1:0] received_code;
	} hec_in_t;

	typedef struct packed {
		logic [CODE_BITS-1:0] code_word;
		logic [LEN_BITS-1:0]  code_length;
		logic [PAR_BITS-1:0]  parity_count;
		logic                 matches_res;
	} hec_out_t;

	typedef struct packed {
		logic [DATA_BITS-1:0] data_mask;
		logic [LEN_BITS-1:0]  code_length;
		logic [PAR_BITS-1:0]  parity_count;
	} hec_cfg_t;

	function automatic int parity_for(input int d);
		int r;
		r = 0;
		while (r < 16 && (1 << r) < d + r + 1) begin
			r++;
		end
		return r;
	endfunction

	function automatic int max_data_len();
		int best;
		best = 1;
		for (int d = 1; d <= 63; d++) begin
			if (d + parity_for(d) <= MAX_CODE_BITS) begin
				best = d;
			end
		end
		return best;
	endfunction

	localparam int MAX_DATA = max_data_len();

	// Codeword position (counted from one) of data bit j: the j-th position that is not
	// a power of two, counting upward.
	function automatic int data_pos(input int j);
		int cnt;
		int res;
		cnt = 0;
		res = 0;
		for (int p = 1; p < 64; p++) begin
			if ((p & (p - 1)) != 0) begin
				if (cnt == j) begin
					res = p;
				end
				cnt++;
			end
		end
		return res;
	endfunction

	// Data bits covered by parity bit k.
	function automatic logic [DATA_BITS-1:0] parity_sel(input int k);
		logic [DATA_BITS-1:0] sel;
		sel = '0;
		for (int j = 0; j < DATA_BITS; j++) begin
			sel[j] = ((data_pos(j) >> k) & 1) != 0;
		end
		return sel;
	endfunction

endpackage

@@ hdl/hec_cfg.sv @@
// Configuration register that holds the clamped data length as a mask, code length and parity count.
module hec_cfg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              data_length_we,
	input  logic [hec_pkg::LEN_BITS-1:0]      data_length,
	output hec_pkg::hec_cfg_t                 cfg
);

	localparam logic [hec_pkg::LEN_BITS-1:0] MaxLen = hec_pkg::LEN_BITS'(hec_pkg::MAX_DATA);

	logic [hec_pkg::LEN_BITS-1:0] len_clamped;
	logic [hec_pkg::PAR_BITS-1:0] par_new;
	hec_pkg::hec_cfg_t            cfg_new;
	hec_pkg::hec_cfg_t            cfg_q;

	always_comb begin
		len_clamped = data_length;
		if (len_clamped == '0) begin
			len_clamped = hec_pkg::LEN_BITS'(1);
		end
		if (len_clamped > MaxLen) begin
			len_clamped = MaxLen;
		end
		par_new = hec_pkg::PAR_BITS'(hec_pkg::parity_for(int'(len_clamped)));
		cfg_new.parity_count = par_new;
		cfg_new.code_length  = len_clamped + hec_pkg::LEN_BITS'(par_new);
		for (int j = 0; j < hec_pkg::DATA_BITS; j++) begin
			cfg_new.data_mask[j] = hec_pkg::LEN_BITS'(j) < len_clamped;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.parity_count <= hec_pkg::PAR_BITS'(hec_pkg::parity_for(int'(hec_pkg::RESET_LENGTH)));
			cfg_q.code_length  <= hec_pkg::RESET_LENGTH
				+ hec_pkg::LEN_BITS'(hec_pkg::parity_for(int'(hec_pkg::RESET_LENGTH)));
			for (int j = 0; j < hec_pkg::DATA_BITS; j++) begin
				cfg_q.data_mask[j] <= hec_pkg::LEN_BITS'(j) < hec_pkg::RESET_LENGTH;
			end
		end else if (data_length_we) begin
			cfg_q <= cfg_new;
		end
	end

	assign cfg = cfg_q;

endmodule

@@ hdl/hec_encode.sv @@
// Data scatter, parity trees and codeword compare for one beat.
module hec_encode (
	input  logic [hec_pkg::DATA_BITS-1:0] data_word,
	input  logic [hec_pkg::CODE_BITS-1:0] received_code,
	input  hec_pkg::hec_cfg_t             cfg,
	output hec_pkg::hec_out_t             result
);

	logic [hec_pkg::DATA_BITS-1:0] data_m;
	logic [hec_pkg::CODE_BITS-1:0] code;

	always_comb begin
		data_m = data_word & cfg.data_mask;
		code   = '0;
		for (int j = 0; j < hec_pkg::DATA_BITS; j++) begin
			code[hec_pkg::data_pos(j) - 1] = data_m[j];
		end
		for (int k = 0; k < hec_pkg::MAX_PARITY; k++) begin
			code[(1 << k) - 1] = ^(data_m & hec_pkg::parity_sel(k));
		end
		result.code_word    = code;
		result.code_length  = cfg.code_length;
		result.parity_count = cfg.parity_count;
		result.matches_res  = received_code == code;
	end

endmodule

@@ hdl/hamming_encode_and_check.sv @@
// Top level of the Hamming encoder and checker with its two-stage beat pipeline.
//
//  Channel  | Direction | Handshake          | Payload
//  in       | input     | in_valid/in_stall  | in_data (data_word, received_code)
//  out      | output    | out_valid/out_stall| out_data (code_word, code_length, ...)
//  config   | input     | data_length_we     | data_length
//
// One beat per cycle is taken unless stalled; it passes beat_s1, then res_s2.
// The input register and the result register each hold one beat, so the input is
// stalled only when both are full and the output is stalled.
// Reset empties both stages and sets the data length to four.
module hamming_encode_and_check (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  hec_pkg::hec_in_t             in_data,
	output logic                         out_valid,
	input  logic                         out_stall,
	output hec_pkg::hec_out_t            out_data,
	input  logic                         data_length_we,
	input  logic [hec_pkg::LEN_BITS-1:0] data_length
);

	hec_pkg::hec_cfg_t cfg;
	hec_pkg::hec_in_t  beat_s1;
	hec_pkg::hec_out_t result;
	hec_pkg::hec_out_t res_s2;
	logic              valid_s1;
	logic              valid_s2;
	logic              adv_s1;

	hec_cfg u_cfg (
		.clk            (clk),
		.arst_n         (arst_n),
		.data_length_we (data_length_we),
		.data_length    (data_length),
		.cfg            (cfg)
	);

	hec_encode u_encode (
		.data_word     (beat_s1.data_word),
		.received_code (beat_s1.received_code),
		.cfg           (cfg),
		.result        (result)
	);

	assign adv_s1   = !valid_s2 || !out_stall;
	assign in_stall = valid_s1 && !adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (!in_stall) begin
				valid_s1 <= in_valid;
			end
			if (adv_s1) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			beat_s1 <= in_data;
		end
		if (adv_s1 && valid_s1) begin
			res_s2 <= result;
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = res_s2;

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && valid_s2 && out_stall))
		else $error("Input stalled while the pipeline has room.");

	a_len_above_par: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.code_length > hec_pkg::LEN_BITS'(out_data.parity_count)))
		else $error("Code length does not exceed the parity count.");

	a_upper_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((out_data.code_word >> out_data.code_length) == '0))
		else $error("Codeword has bits set above its length.");

	a_no_loss: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv_s1) |=> valid_s1)
		else $error("Held beat dropped from the input register.");

endmodule

@@ tb/tb_hamming_encode_and_check.sv @@
// Self-checking testbench of the Hamming encoder and checker with a built-in codeword predictor.
module tb_hamming_encode_and_check;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int PIPE_LATENCY   = 2;

	logic                         clk            = 1'b0;
	logic                         arst_n         = 1'b0;
	logic                         in_valid       = 1'b0;
	logic                         in_stall;
	hec_pkg::hec_in_t             in_data        = '0;
	logic                         out_valid;
	logic                         out_stall      = 1'b0;
	hec_pkg::hec_out_t            out_data;
	logic                         data_length_we = 1'b0;
	logic [hec_pkg::LEN_BITS-1:0] data_length    = '0;

	logic [hec_pkg::LEN_BITS-1:0] length_reg = hec_pkg::RESET_LENGTH;
	hec_pkg::hec_out_t            expected_codes[$];
	int                           error_count   = 0;
	int                           stall_cycles  = 0;
	int                           send_idle_pct = 0;
	int                           recv_idle_pct = 0;
	bit                           quiet         = 1'b0;

	hamming_encode_and_check u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.in_data        (in_data),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.out_data       (out_data),
		.data_length_we (data_length_we),
		.data_length    (data_length)
	);

	always begin
		#1ns clk = 1'b1;
		#1ns clk = 1'b0;
	end

	function automatic hec_pkg::hec_out_t hamming_encode(
		input logic [hec_pkg::LEN_BITS-1:0] len,
		input hec_pkg::hec_in_t item
	);
		hec_pkg::hec_out_t res;
		int d;
		int r;
		int di;
		int acc;
		d = int'(len);
		if (d == 0) begin
			d = 1;
		end
		if (d > hec_pkg::MAX_DATA) begin
			d = hec_pkg::MAX_DATA;
		end
		r = 0;
		while ((1 << r) < d + r + 1) begin
			r++;
		end
		res = '0;
		acc = 0;
		di = d;
		for (int p = d + r; p >= 1; p--) begin
			if ((p & (p - 1)) != 0) begin
				di--;
				if (item.data_word[di]) begin
					res.code_word[p-1] = 1'b1;
					acc ^= p;
				end
			end
		end
		for (int k = 0; k < r; k++) begin
			if (acc[k]) begin
				res.code_word[(1 << k) - 1] = 1'b1;
			end
		end
		res.code_length  = hec_pkg::LEN_BITS'(d + r);
		res.parity_count = hec_pkg::PAR_BITS'(r);
		res.matches_res  = (item.received_code == res.code_word);
		return res;
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	always @(posedge clk) begin
		out_stall <= !quiet && ($urandom_range(99) < recv_idle_pct);
	end

	always @(posedge clk) begin
		hec_pkg::hec_out_t golden;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_codes.size() == 0) begin
				$error("unexpected result beat: %h", out_data);
				error_count++;
			end else begin
				golden = expected_codes.pop_front();
				if (out_data.code_word !== golden.code_word) begin
					$error("code_word mismatch: expected %h, actual %h",
						golden.code_word, out_data.code_word);
					error_count++;
				end
				if (out_data.code_length !== golden.code_length) begin
					$error("code_length mismatch: expected %0d, actual %0d",
						golden.code_length, out_data.code_length);
					error_count++;
				end
				if (out_data.parity_count !== golden.parity_count) begin
					$error("parity_count mismatch: expected %0d, actual %0d",
						golden.parity_count, out_data.parity_count);
					error_count++;
				end
				if (out_data.matches_res !== golden.matches_res) begin
					$error("matches_res mismatch: expected %b, actual %b",
						golden.matches_res, out_data.matches_res);
					error_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= WATCHDOG_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	task automatic send_beat(input hec_pkg::hec_in_t item);
		while (!quiet && ($urandom_range(99) < send_idle_pct)) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= item;
		do begin
			@(posedge clk);
		end while (in_stall);
		expected_codes.push_back(hamming_encode(length_reg, item));
	endtask

	task automatic send_with_code(
		input logic [hec_pkg::DATA_BITS-1:0] data,
		input logic [hec_pkg::CODE_BITS-1:0] flip
	);
		hec_pkg::hec_in_t item;
		hec_pkg::hec_out_t golden;
		item.data_word     = data;
		item.received_code = '0;
		golden = hamming_encode(length_reg, item);
		item.received_code = golden.code_word ^ flip;
		send_beat(item);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (expected_codes.size() != 0) begin
			@(posedge clk);
		end
		repeat (PIPE_LATENCY + 1) @(posedge clk);
	endtask

	task automatic set_length(input logic [hec_pkg::LEN_BITS-1:0] len);
		drain_results();
		data_length_we <= 1'b1;
		data_length    <= len;
		@(posedge clk);
		data_length_we <= 1'b0;
		length_reg = len;
	endtask

	task automatic test_reset_length();
		send_with_code('0, '0);
		send_with_code('1, '0);
		send_with_code(57'h5, 63'h1);
		send_beat('{data_word: 57'hA, received_code: '1});
	endtask

	task automatic test_length_extremes();
		set_length(6'd0);
		send_with_code('1, '0);
		send_with_code('0, 63'h1 << 62);
		set_length(6'd1);
		send_with_code(57'h1, '0);
		send_with_code(57'h1, 63'h4);
		set_length(6'd57);
		send_with_code('1, '0);
		send_with_code('0, '0);
		send_with_code({19{3'b101}}, '0);
		send_with_code(57'h1, 63'h1 << 62);
		send_beat('{data_word: '0, received_code: '1});
		set_length(6'd63);
		send_with_code('1, '0);
		send_with_code(57'h1 << 56, 63'h1 << 30);
		set_length(6'd58);
		send_with_code('1, '0);
		set_length(6'd11);
		send_with_code('1, '0);
		send_with_code(57'h400, 63'h1 << 14);
		set_length(6'd26);
		send_with_code(57'h2AAAAAA, '0);
	endtask

	task automatic test_random_traffic(input int send_pct, input int recv_pct, input int count);
		hec_pkg::hec_in_t item;
		hec_pkg::hec_out_t golden;
		logic [63:0] rnd;
		logic [hec_pkg::LEN_BITS-1:0] len;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		for (int i = 0; i < count; i++) begin
			if (i % 34 == 0) begin
				case ($urandom_range(9))
					0, 1, 2, 3: len = hec_pkg::LEN_BITS'($urandom_range(1, 8));
					4: len = 6'd0;
					5: len = 6'd57;
					6: len = hec_pkg::LEN_BITS'($urandom_range(58, 63));
					default: len = hec_pkg::LEN_BITS'($urandom_range(0, 63));
				endcase
				set_length(len);
			end
			quiet = (i % 40) < 8;
			rnd = rand64();
			item.data_word     = rnd[hec_pkg::DATA_BITS-1:0];
			item.received_code = '0;
			golden = hamming_encode(length_reg, item);
			rnd = rand64();
			case ($urandom_range(3))
				0, 1: item.received_code = golden.code_word;
				2: item.received_code = golden.code_word ^ (63'h1 << $urandom_range(62));
				default: item.received_code = rnd[hec_pkg::CODE_BITS-1:0];
			endcase
			send_beat(item);
		end
		quiet = 1'b0;
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_length();
		test_length_extremes();
		test_random_traffic(9, 51, 134);
		test_random_traffic(51, 9, 134);
		test_random_traffic(0, 0, 134);
		drain_results();
		repeat (8) @(posedge clk);
		if (error_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
